// File: rtl/rbsa_pkg.sv
// ----------------------------------------------------------------------------
// rbsa_pkg
// Shared types and constants of the rounded box shadow alpha block.
// ----------------------------------------------------------------------------
package rbsa_pkg;

    // configuration registers, fixed widths
    typedef struct packed {
        logic [12:0] frame_width;
        logic [12:0] frame_height;
        logic [7:0]  margin;
        logic [7:0]  corner_radius;
        logic [15:0] falloff_scale;
    } rbsa_cfg_t;

    typedef enum logic [2:0] {
        REG_FRAME_WIDTH   = 3'd0,
        REG_FRAME_HEIGHT  = 3'd1,
        REG_MARGIN        = 3'd2,
        REG_CORNER_RADIUS = 3'd3,
        REG_FALLOFF_SCALE = 3'd4
    } rbsa_reg_t;

    localparam logic [12:0] FRAME_WIDTH_RST   = 13'd1;
    localparam logic [12:0] FRAME_HEIGHT_RST  = 13'd1;
    localparam logic [7:0]  MARGIN_RST        = 8'd14;
    localparam logic [7:0]  CORNER_RADIUS_RST = 8'd8;
    localparam logic [15:0] FALLOFF_SCALE_RST = 16'd963;

    localparam int PIX_W   = 12;
    localparam int ALPHA_W = 6;
    // distances at or above 2^D_W half pixels always give zero alpha
    // unless the falloff scale is zero
    localparam int D_W     = 10;
    localparam int E_W     = 2 * D_W + 16;
    localparam int N_THR   = 40;

    // floor(ln(40/a) * 2^18), a = 1..40
    localparam logic [19:0] EXP_THRESH [N_THR] = '{
        20'd967017, 20'd785313, 20'd679022, 20'd603608, 20'd545113, 20'd497318,
        20'd456908, 20'd421904, 20'd391028, 20'd363408, 20'd338423, 20'd315614,
        20'd294631, 20'd275204, 20'd257118, 20'd240200, 20'd224307, 20'd209324,
        20'd195150, 20'd181704, 20'd168914, 20'd156719, 20'd145066, 20'd133909,
        20'd123208, 20'd112927, 20'd103033, 20'd93500,  20'd84301,  20'd75414,
        20'd66818,  20'd58495,  20'd50429,  20'd42603,  20'd35004,  20'd27619,
        20'd20437,  20'd13446,  20'd6636,   20'd0
    };

endpackage

// File: rtl/rbsa_geom.sv
// ----------------------------------------------------------------------------
// rbsa_geom
// Box geometry: per-axis excess, squares and their sum (three stages).
// ----------------------------------------------------------------------------
module rbsa_geom #(
    parameter int MAX_DIM = 4096,
    parameter int EW      = 13,
    parameter int GW      = 16,
    parameter int PW      = 15,
    parameter int SW      = 31
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [rbsa_pkg::PIX_W-1:0] pixel_x,
    input  logic [rbsa_pkg::PIX_W-1:0] pixel_y,
    input  rbsa_pkg::rbsa_cfg_t       cfg,
    output logic                      out_valid,
    output logic [SW-1:0]             out_sum,
    output logic signed [GW-1:0]      out_inner
);
    import rbsa_pkg::*;

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [GW-1:0] qx_reg, qy_reg, qx_next, qy_next;
    logic [2*PW-1:0]      sqx_reg, sqy_reg;
    logic signed [GW-1:0] inner2_reg, inner2_next, inner3_reg;
    logic [SW-1:0]        sum_reg;
    logic [PW-1:0]        px, py;
    logic [EW-1:0]        w_sat, h_sat;

    function automatic logic signed [GW-1:0] axis_excess(
        input logic [PIX_W-1:0] p,
        input logic [EW-1:0]    size,
        input logic [7:0]       m,
        input logic [7:0]       r
    );
        logic signed [GW-1:0] a;
        logic signed [GW-1:0] span;
        a    = signed'(GW'({p, 1'b1})) - signed'(GW'(size));
        if (a < 0) begin
            a = -a;
        end
        span = signed'(GW'(size)) - signed'(GW'({m, 1'b0})) - signed'(GW'({r, 1'b0}));
        return a - span;
    endfunction

    always_comb begin
        w_sat = (32'(cfg.frame_width) > MAX_DIM) ? EW'(MAX_DIM) : EW'(cfg.frame_width);
        h_sat = (32'(cfg.frame_height) > MAX_DIM) ? EW'(MAX_DIM) : EW'(cfg.frame_height);
        qx_next = axis_excess(pixel_x, w_sat, cfg.margin, cfg.corner_radius);
        qy_next = axis_excess(pixel_y, h_sat, cfg.margin, cfg.corner_radius);
        px = (qx_reg > 0) ? qx_reg[PW-1:0] : '0;
        py = (qy_reg > 0) ? qy_reg[PW-1:0] : '0;
        inner2_next = (qx_reg > qy_reg) ? qx_reg : qy_reg;
        if (inner2_next > 0) begin
            inner2_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            qx_reg     <= qx_next;
            qy_reg     <= qy_next;
            sqx_reg    <= px * px;
            sqy_reg    <= py * py;
            inner2_reg <= inner2_next;
            sum_reg    <= SW'(sqx_reg) + SW'(sqy_reg);
            inner3_reg <= inner2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_sum   = sum_reg;
    assign out_inner = inner3_reg;

endmodule

// File: rtl/rbsa_isqrt.sv
// ----------------------------------------------------------------------------
// rbsa_isqrt
// Pipelined integer square root, two result bits per stage, with a side tag.
// ----------------------------------------------------------------------------
module rbsa_isqrt #(
    parameter int SW = 31,
    parameter int RW = 16,
    parameter int TW = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          en,
    input  logic          in_valid,
    input  logic [SW-1:0] in_value,
    input  logic [TW-1:0] in_tag,
    output logic          out_valid,
    output logic [RW-1:0] out_root,
    output logic [TW-1:0] out_tag
);

    localparam int NST   = (RW + 1) / 2;
    localparam int NSTEP = 2 * NST;
    localparam int REMW  = NSTEP + 3;
    localparam int VW    = 2 * NSTEP;

    typedef struct packed {
        logic [REMW-1:0]  rem;
        logic [NSTEP-1:0] root;
        logic [VW-1:0]    val;
    } sq_t;

    function automatic sq_t sq_step(input sq_t s);
        sq_t             o;
        logic [REMW-1:0] cur;
        logic [REMW-1:0] trial;
        cur   = {s.rem[REMW-3:0], s.val[VW-1:VW-2]};
        trial = {1'b0, s.root, 2'b01};
        if (cur >= trial) begin
            o.rem  = cur - trial;
            o.root = {s.root[NSTEP-2:0], 1'b1};
        end else begin
            o.rem  = cur;
            o.root = {s.root[NSTEP-2:0], 1'b0};
        end
        o.val = {s.val[VW-3:0], 2'b00};
        return o;
    endfunction

    sq_t             st_reg  [NST];
    logic [TW-1:0]   tag_reg [NST];
    logic [NST-1:0]  v_reg;

    for (genvar g = 0; g < NST; g++) begin : g_stage
        sq_t           stage_in;
        sq_t           stage_next;
        logic [TW-1:0] tag_in;
        logic          v_in;
        if (g == 0) begin : g_first
            always_comb begin
                stage_in.rem  = '0;
                stage_in.root = '0;
                stage_in.val  = VW'(in_value);
                tag_in        = in_tag;
                v_in          = in_valid;
            end
        end else begin : g_rest
            always_comb begin
                stage_in = st_reg[g-1];
                tag_in   = tag_reg[g-1];
                v_in     = v_reg[g-1];
            end
        end
        always_comb begin
            stage_next = sq_step(sq_step(stage_in));
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g] <= 1'b0;
            end else if (en) begin
                v_reg[g] <= v_in;
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                st_reg[g]  <= stage_next;
                tag_reg[g] <= tag_in;
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_root  = st_reg[NST-1].root[RW-1:0];
    assign out_tag   = tag_reg[NST-1];

endmodule

// File: rtl/rbsa_alpha.sv
// ----------------------------------------------------------------------------
// rbsa_alpha
// Signed distance, Gaussian exponent and table lookup to the alpha word.
// ----------------------------------------------------------------------------
module rbsa_alpha #(
    parameter int RW = 16,
    parameter int GW = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [RW-1:0]                 root,
    input  logic signed [GW-1:0]          inner,
    input  rbsa_pkg::rbsa_cfg_t           cfg,
    output logic                          out_valid,
    output logic [rbsa_pkg::ALPHA_W-1:0]  out_alpha
);
    import rbsa_pkg::*;

    localparam int DW = ((RW > GW) ? RW : GW) + 2;

    logic signed [DW-1:0] d_next;
    logic                 v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic                 neg1_reg, big1_reg, neg2_reg, big2_reg;
    logic [D_W-1:0]       d1_reg;
    logic [2*D_W-1:0]     dsq2_reg;
    logic [E_W-1:0]       e3_reg;
    logic                 zero3_reg, all3_reg;
    logic [N_THR-1:0]     hit4_reg, hit4_next;
    logic [ALPHA_W-1:0]   alpha5_reg;

    always_comb begin
        d_next = signed'(DW'(root)) + DW'(inner) - signed'(DW'({cfg.corner_radius, 1'b0}));
        for (int a = 0; a < N_THR; a++) begin
            hit4_next[a] = !zero3_reg && (all3_reg || (e3_reg <= E_W'(EXP_THRESH[a])));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg   <= d_next[DW-1];
            big1_reg   <= !d_next[DW-1] && (|d_next[DW-2:D_W]);
            d1_reg     <= d_next[D_W-1:0];
            dsq2_reg   <= d1_reg * d1_reg;
            neg2_reg   <= neg1_reg;
            big2_reg   <= big1_reg;
            e3_reg     <= dsq2_reg * cfg.falloff_scale;
            zero3_reg  <= neg2_reg || (big2_reg && (cfg.falloff_scale != '0));
            all3_reg   <= big2_reg && (cfg.falloff_scale == '0);
            hit4_reg   <= hit4_next;
            alpha5_reg <= ALPHA_W'($countones(hit4_reg));
        end
    end

    assign out_valid = v5_reg;
    assign out_alpha = alpha5_reg;

endmodule

// File: rtl/rounded_box_shadow_alpha.sv
// ----------------------------------------------------------------------------
// rounded_box_shadow_alpha
// Drop-shadow alpha of one pixel around a rounded rectangle, fully pipelined.
// ----------------------------------------------------------------------------
//  channel  | ports                               | word
//  ---------+-------------------------------------+---------------------------
//  input    | s_valid s_ready s_pixel_x s_pixel_y | one pixel coordinate
//  result   | m_valid m_ready m_shadow_alpha      | alpha 0..40
//  config   | psel penable pwrite paddr pwdata    | five registers, 4*i
//
//  The pipe runs through the geometry, square root and alpha sections; the square
//  root stages, two root bits each, are its longest part. One word per cycle
//  sustained while the output is not stalled. The whole pipe advances when the
//  output register is empty or taken, so a stall freezes every stage in place;
//  valid bits ride along with the data. Reset (aresetn low, synchronous) clears
//  the valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module rounded_box_shadow_alpha #(
    parameter int MAX_DIM = 4096
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rbsa_pkg::PIX_W-1:0]    s_pixel_x,
    input  logic [rbsa_pkg::PIX_W-1:0]    s_pixel_y,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rbsa_pkg::ALPHA_W-1:0]  m_shadow_alpha,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [4:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import rbsa_pkg::*;

    // clamped frame size width, then half-pixel geometry widths
    localparam int CW = $clog2(MAX_DIM + 1);
    localparam int EW = (CW > 13) ? CW : 13;
    localparam int GW = EW + 3;
    localparam int PW = GW - 1;
    localparam int SW = 2 * PW + 1;
    localparam int RW = PW + 1;

    rbsa_cfg_t     cfg_reg;
    rbsa_reg_t     reg_idx;
    logic          wr_en;
    logic          en;

    logic          g_valid;
    logic [SW-1:0] g_sum;
    logic signed [GW-1:0] g_inner;
    logic          r_valid;
    logic [RW-1:0] r_root;
    logic [GW-1:0] r_tag;

    // register file
    assign pready  = 1'b1;
    assign reg_idx = rbsa_reg_t'(paddr[4:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_width   <= FRAME_WIDTH_RST;
            cfg_reg.frame_height  <= FRAME_HEIGHT_RST;
            cfg_reg.margin        <= MARGIN_RST;
            cfg_reg.corner_radius <= CORNER_RADIUS_RST;
            cfg_reg.falloff_scale <= FALLOFF_SCALE_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_FRAME_WIDTH:   cfg_reg.frame_width   <= pwdata[12:0];
                REG_FRAME_HEIGHT:  cfg_reg.frame_height  <= pwdata[12:0];
                REG_MARGIN:        cfg_reg.margin        <= pwdata[7:0];
                REG_CORNER_RADIUS: cfg_reg.corner_radius <= pwdata[7:0];
                REG_FALLOFF_SCALE: cfg_reg.falloff_scale <= pwdata[15:0];
                default: ;  // unmapped offsets are ignored
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FRAME_WIDTH:   prdata = 32'(cfg_reg.frame_width);
            REG_FRAME_HEIGHT:  prdata = 32'(cfg_reg.frame_height);
            REG_MARGIN:        prdata = 32'(cfg_reg.margin);
            REG_CORNER_RADIUS: prdata = 32'(cfg_reg.corner_radius);
            REG_FALLOFF_SCALE: prdata = 32'(cfg_reg.falloff_scale);
            default:           prdata = '0;
        endcase
    end

    // global pipe advance: output register free or being drained
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // excess per axis, squares, sum of squares
    rbsa_geom #(
        .MAX_DIM (MAX_DIM),
        .EW      (EW),
        .GW      (GW),
        .PW      (PW),
        .SW      (SW)
    ) u_geom (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .pixel_x   (s_pixel_x),
        .pixel_y   (s_pixel_y),
        .cfg       (cfg_reg),
        .out_valid (g_valid),
        .out_sum   (g_sum),
        .out_inner (g_inner)
    );

    // root of the outside distance; inside term travels as the tag
    rbsa_isqrt #(
        .SW (SW),
        .RW (RW),
        .TW (GW)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (g_valid),
        .in_value  (g_sum),
        .in_tag    (g_inner),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_tag   (r_tag)
    );

    // distance, exponent, threshold count; last stage is the output register
    rbsa_alpha #(
        .RW (RW),
        .GW (GW)
    ) u_alpha (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (r_valid),
        .root      (r_root),
        .inner     (signed'(r_tag)),
        .cfg       (cfg_reg),
        .out_valid (m_valid),
        .out_alpha (m_shadow_alpha)
    );

endmodule

// File: rtl/rbsa_checker.sv
// ----------------------------------------------------------------------------
// rbsa_checker
// Port-level assertions for the shadow alpha block, bound to the top level.
// ----------------------------------------------------------------------------
module rbsa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rbsa_pkg::ALPHA_W-1:0]  m_shadow_alpha
);

    // a held result word does not change
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_shadow_alpha))
        else $error("result word changed while stalled");

    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_shadow_alpha <= 6'd40)
        else $error("alpha above 40");

    // input side moves exactly when the output register can advance
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready == (!m_valid || m_ready))
        else $error("input ready out of step with output stall");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind rounded_box_shadow_alpha rbsa_checker u_rbsa_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_shadow_alpha (m_shadow_alpha)
);
